### hw/rtl/sgd_pkg.sv
package sgd_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned TimeW  = 48;
    localparam int unsigned DlineW = 49;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [DataW-1:0] ThresholdRst = 32'd100;
    localparam logic [DataW-1:0] CooldownRst  = 32'd0;

    localparam logic [DataW-1:0] SatMax = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0] SatMin = 32'h8000_0000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_COOLDOWN  = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        GEST_NONE  = 3'd0,
        GEST_LEFT  = 3'd1,
        GEST_RIGHT = 3'd2,
        GEST_UP    = 3'd3,
        GEST_DOWN  = 3'd4
    } t_gesture;

    typedef struct packed {
        logic [DataW-1:0] threshold;
        logic [DataW-1:0] cooldown_len;
    } t_cfg;

    typedef struct packed {
        logic                    axis_select;
        logic signed [DataW-1:0] delta;
        logic                    sync_mark;
        logic [TimeW-1:0]        time_now;
    } t_event;

endpackage

### hw/rtl/sgd_cfg.sv
module sgd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sgd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [sgd_pkg::DataW-1:0]   i_cfg_data,
    output sgd_pkg::t_cfg               o_cfg
);

    sgd_pkg::t_cfg r_cfg;
    sgd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                sgd_pkg::REG_THRESHOLD: n_cfg.threshold    = i_cfg_data;
                sgd_pkg::REG_COOLDOWN:  n_cfg.cooldown_len = i_cfg_data;
                default:                n_cfg              = r_cfg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= sgd_pkg::ThresholdRst;
            r_cfg.cooldown_len <= sgd_pkg::CooldownRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/sgd_core.sv
module sgd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  sgd_pkg::t_event     i_evt,
    input  sgd_pkg::t_cfg       i_cfg,
    output sgd_pkg::t_gesture   o_gesture
);

    logic signed [sgd_pkg::DataW-1:0] r_sum_h;
    logic signed [sgd_pkg::DataW-1:0] r_sum_v;
    logic                             r_in_cd;
    logic [sgd_pkg::DlineW-1:0]       r_deadline;

    logic signed [sgd_pkg::DataW-1:0] n_sum_h;
    logic signed [sgd_pkg::DataW-1:0] n_sum_v;
    logic                             n_in_cd;
    logic [sgd_pkg::DlineW-1:0]       n_deadline;
    sgd_pkg::t_gesture                n_gesture;

    logic signed [sgd_pkg::DataW-1:0] sel_sum;
    logic        [sgd_pkg::DataW:0]   wide_sum;
    logic signed [sgd_pkg::DataW-1:0] sat_sum;
    logic signed [sgd_pkg::DataW-1:0] acc_h;
    logic signed [sgd_pkg::DataW-1:0] acc_v;
    logic        [sgd_pkg::DataW-1:0] mag_h;
    logic        [sgd_pkg::DataW-1:0] mag_v;
    logic        [sgd_pkg::DataW:0]   mag_tot;
    logic                             fire;
    logic                             cd_done;

    // Saturating add of the delta into the selected axis
    always_comb begin
        sel_sum  = i_evt.axis_select ? r_sum_v : r_sum_h;
        wide_sum = {sel_sum[sgd_pkg::DataW-1], sel_sum}
                 + {i_evt.delta[sgd_pkg::DataW-1], i_evt.delta};
        if (wide_sum[sgd_pkg::DataW] != wide_sum[sgd_pkg::DataW-1]) begin
            sat_sum = wide_sum[sgd_pkg::DataW] ? sgd_pkg::SatMin : sgd_pkg::SatMax;
        end else begin
            sat_sum = wide_sum[sgd_pkg::DataW-1:0];
        end
        acc_h = i_evt.axis_select ? r_sum_h : sat_sum;
        acc_v = i_evt.axis_select ? sat_sum : r_sum_v;
    end

    always_comb begin
        mag_h   = acc_h[sgd_pkg::DataW-1] ? (~acc_h + 1'b1) : acc_h;
        mag_v   = acc_v[sgd_pkg::DataW-1] ? (~acc_v + 1'b1) : acc_v;
        mag_tot = {1'b0, mag_h} + {1'b0, mag_v};
        fire    = !r_in_cd && i_evt.sync_mark && (mag_tot >= {1'b0, i_cfg.threshold});
        cd_done = i_evt.sync_mark
               && ({1'b0, i_evt.time_now} >= r_deadline);
    end

    always_comb begin
        n_sum_h    = r_sum_h;
        n_sum_v    = r_sum_v;
        n_in_cd    = r_in_cd;
        n_deadline = r_deadline;
        n_gesture  = sgd_pkg::GEST_NONE;
        if (r_in_cd) begin
            // hold sums at zero, leave on a late enough sync word
            n_sum_h = '0;
            n_sum_v = '0;
            if (cd_done) begin
                n_in_cd = 1'b0;
            end
        end else if (fire) begin
            n_sum_h    = '0;
            n_sum_v    = '0;
            n_in_cd    = 1'b1;
            n_deadline = {1'b0, i_evt.time_now}
                       + {{(sgd_pkg::DlineW-sgd_pkg::DataW){1'b0}}, i_cfg.cooldown_len};
            if (mag_h >= mag_v) begin
                n_gesture = acc_h[sgd_pkg::DataW-1] ? sgd_pkg::GEST_LEFT
                                                    : sgd_pkg::GEST_RIGHT;
            end else begin
                n_gesture = acc_v[sgd_pkg::DataW-1] ? sgd_pkg::GEST_UP
                                                    : sgd_pkg::GEST_DOWN;
            end
        end else begin
            n_sum_h = acc_h;
            n_sum_v = acc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_h    <= '0;
            r_sum_v    <= '0;
            r_in_cd    <= 1'b0;
            r_deadline <= '0;
        end else if (i_adv) begin
            r_sum_h    <= n_sum_h;
            r_sum_v    <= n_sum_v;
            r_in_cd    <= n_in_cd;
            r_deadline <= n_deadline;
        end
    end

    assign o_gesture = n_gesture;

    a_fire_enters_cd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && n_gesture != sgd_pkg::GEST_NONE) |=> r_in_cd)
        else $error("gesture reported without entering cooldown");

    a_cd_sums_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_cd |-> (r_sum_h == '0 && r_sum_v == '0))
        else $error("accumulators not zero during cooldown");

    a_cd_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_cd |-> (n_gesture == sgd_pkg::GEST_NONE))
        else $error("gesture reported during cooldown");

endmodule

### hw/rtl/swipe_gesture_detector.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+--------------------------------------
// in        | input     | i_in_valid / o_in_stall    | i_axis_select i_delta i_sync_mark
//           |           |                            | i_time_now
// out       | output    | o_out_valid / i_out_stall  | o_gesture
// cfg       | input     | i_cfg_we                   | i_cfg_index i_cfg_data
//
// One word per cycle sustained while the output is not stalled; each word yields exactly one gesture word.
// Each word passes through an input register, then the accumulator/decision logic
// feeding the result register.
// Accumulators and cooldown state update only when the input register moves a
// word into the result register, so state follows word order exactly.
// A stall on the output holds both registers while the result register is full; the input
// stalls only when both are full and the output cannot drain this cycle.
// Reset (synchronous, active low) clears sums, cooldown and valid flags and loads
// threshold 100 and cooldown length 0.
module swipe_gesture_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_axis_select,
    input  logic signed [sgd_pkg::DataW-1:0]  i_delta,
    input  logic                              i_sync_mark,
    input  logic        [sgd_pkg::TimeW-1:0]  i_time_now,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic        [2:0]                 o_gesture,
    input  logic                              i_cfg_we,
    input  logic        [sgd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic        [sgd_pkg::DataW-1:0]  i_cfg_data
);

    sgd_pkg::t_cfg     cfg;
    sgd_pkg::t_event   r_evt;
    logic              r_evt_vld;
    sgd_pkg::t_gesture r_gesture;
    logic              r_out_vld;
    sgd_pkg::t_gesture core_gesture;

    logic out_free;
    logic adv;
    logic in_acc;

    // The result register can take a word if empty or draining this cycle
    assign out_free = !r_out_vld || !i_out_stall;
    assign adv      = r_evt_vld && out_free;
    assign in_acc   = i_in_valid && !o_in_stall;

    assign o_in_stall = r_evt_vld && !out_free;

    sgd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sgd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_evt     (r_evt),
        .i_cfg     (cfg),
        .o_gesture (core_gesture)
    );

    // Input register: capture a new word whenever the slot is free or advancing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_vld <= 1'b0;
        end else if (!r_evt_vld || adv) begin
            r_evt_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_evt.axis_select <= i_axis_select;
            r_evt.delta       <= i_delta;
            r_evt.sync_mark   <= i_sync_mark;
            r_evt.time_now    <= i_time_now;
        end
    end

    // Result register: load on advance, drop the valid once the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_gesture <= core_gesture;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_gesture   = r_gesture;

endmodule
